>>> rtl/eld_pkg.sv
// ----------------------------------------------------------------------------
// eld_pkg
// Shared types and constants for the epipolar line point distance pipeline.
// ----------------------------------------------------------------------------
package eld_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int COEF_W = 32;
	localparam int NUM_COEF = 9;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAIR0 = 3'd0,
		REG_PAIR1 = 3'd1,
		REG_PAIR2 = 3'd2,
		REG_PAIR3 = 3'd3,
		REG_LAST  = 3'd4
	} cfg_reg_t;

	localparam int NORM_W = 31;      // scaled line normal terms, signed
	localparam int SQ_W = 62;        // normalized sum of squares
	localparam int ROOT_W = 31;      // integer root of SQ_W-bit value
	localparam int SH_W = 6;         // shift amounts
	localparam int QUO_W = 24;       // quotient / distance width
	localparam int DVD_W = 56;       // dividend width
	localparam int LIM_W = 55;       // saturation limit width
	localparam int FRONT_STAGES = 7;
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS = 24;

	localparam logic [QUO_W-1:0] POS_CAP = 24'h7FFFFF;
	localparam logic [QUO_W-1:0] NEG_CAP = 24'h800000;

	typedef struct packed {
		logic            neg;
		logic            deg;
		logic [SH_W-1:0] h;
	} side_t;

endpackage

>>> rtl/epipolar_line_point_distance.sv
// ----------------------------------------------------------------------------
// epipolar_line_point_distance
// Signed distance of a right image point to the epipolar line of its match.
// ----------------------------------------------------------------------------
// Throughput: one point pair per cycle; busy stays low, start may be held.
// Depth is set by the 31-stage root pipeline and the 24-stage quotient pipeline.
// Reset clears all valid bits and the nine coefficients to zero.
// The result is shown for one cycle only; the receiver cannot stall it.
module epipolar_line_point_distance #(
	parameter int COORD_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// point pair
	input  logic                                   start,
	output logic                                   busy,
	input  logic [COORD_BITS-1:0]                  left_x,
	input  logic [COORD_BITS-1:0]                  left_y,
	input  logic [COORD_BITS-1:0]                  right_x,
	input  logic [COORD_BITS-1:0]                  right_y,
	// result
	output logic                                   done,
	output logic signed [eld_pkg::QUO_W-1:0]       distance,
	output logic                                   degenerate,
	output logic                                   saturated,
	// coefficient writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [eld_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [eld_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int NW = COORD_BITS + 40;
	localparam int LATENCY = eld_pkg::FRONT_STAGES + eld_pkg::SQRT_STEPS
		+ eld_pkg::DIV_STEPS + 2;

	// fully pipelined, never stalls
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// F held row-major, Q1.31
	logic signed [eld_pkg::COEF_W-1:0] coef_q [eld_pkg::NUM_COEF];
	logic cfg_wr;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < eld_pkg::NUM_COEF; i++) coef_q[i] <= '0;
		end else if (cfg_wr) begin
			case (eld_pkg::cfg_reg_t'(cfg_index))
				eld_pkg::REG_PAIR0: begin
					coef_q[0] <= cfg_data[31:0];
					coef_q[1] <= cfg_data[63:32];
				end
				eld_pkg::REG_PAIR1: begin
					coef_q[2] <= cfg_data[31:0];
					coef_q[3] <= cfg_data[63:32];
				end
				eld_pkg::REG_PAIR2: begin
					coef_q[4] <= cfg_data[31:0];
					coef_q[5] <= cfg_data[63:32];
				end
				eld_pkg::REG_PAIR3: begin
					coef_q[6] <= cfg_data[31:0];
					coef_q[7] <= cfg_data[63:32];
				end
				eld_pkg::REG_LAST: begin
					coef_q[8] <= cfg_data[31:0];
				end
				default: begin
					// unused index: write dropped
				end
			endcase
		end
	end

	// front end: line terms, scaling, numerator, normalized sum of squares
	logic                         fe_valid;
	logic [eld_pkg::SQ_W-1:0]     fe_sq;
	logic [NW-1:0]                fe_anum;
	eld_pkg::side_t               fe_side;

	eld_line #(
		.CB(COORD_BITS)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.xl       (left_x),
		.yl       (left_y),
		.xr       (right_x),
		.yr       (right_y),
		.coef     (coef_q),
		.out_valid(fe_valid),
		.sq       (fe_sq),
		.anum     (fe_anum),
		.side     (fe_side)
	);

	// root of the normalized sum of squares
	logic                           rt_valid;
	logic [eld_pkg::ROOT_W-1:0]     rt_root;
	logic [NW-1:0]                  rt_anum;
	eld_pkg::side_t                 rt_side;

	eld_sqrt #(
		.AN(NW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fe_valid),
		.sq       (fe_sq),
		.anum_in  (fe_anum),
		.side_in  (fe_side),
		.out_valid(rt_valid),
		.root     (rt_root),
		.anum_out (rt_anum),
		.side_out (rt_side)
	);

	// |N| * 2^h / root, rounded, clamped, signed
	eld_div #(
		.AN(NW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.root      (rt_root),
		.anum      (rt_anum),
		.side_in   (rt_side),
		.done      (done),
		.distance  (distance),
		.degenerate(degenerate),
		.saturated (saturated)
	);

	// a result only follows an accepted pair
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done without matching start");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> (distance == '0) && !saturated)
		else $error("degenerate result not zero");

	a_sat_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |->
			(distance == $signed(eld_pkg::POS_CAP)) || (distance == $signed(eld_pkg::NEG_CAP)))
		else $error("saturated result not at a limit");

	a_coef_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr |=> $stable(coef_q[0]) && $stable(coef_q[4]) && $stable(coef_q[8]))
		else $error("coefficient changed without a write");

endmodule

>>> rtl/eld_line.sv
// ----------------------------------------------------------------------------
// eld_line
// Line terms, normal scaling, numerator and normalized sum of squares.
// ----------------------------------------------------------------------------
module eld_line #(
	parameter int CB = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic [CB-1:0]                        xl,
	input  logic [CB-1:0]                        yl,
	input  logic [CB-1:0]                        xr,
	input  logic [CB-1:0]                        yr,
	input  logic signed [eld_pkg::COEF_W-1:0]    coef [eld_pkg::NUM_COEF],
	output logic                                 out_valid,
	output logic [eld_pkg::SQ_W-1:0]             sq,
	output logic [CB+39:0]                       anum,
	output eld_pkg::side_t                       side
);

	localparam int PW = CB + 33;   // coefficient times coordinate
	localparam int AW = CB + 35;   // line terms
	localparam int MW = CB + 32;   // scaled normal times coordinate
	localparam int NW = CB + 40;   // numerator

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1: six products
	logic signed [PW-1:0] p_s1 [6];
	logic [CB-1:0] xr_s1, yr_s1;
	always_ff @(posedge clk) begin
		p_s1[0] <= coef[0] * $signed({1'b0, xl});
		p_s1[1] <= coef[1] * $signed({1'b0, yl});
		p_s1[2] <= coef[3] * $signed({1'b0, xl});
		p_s1[3] <= coef[4] * $signed({1'b0, yl});
		p_s1[4] <= coef[6] * $signed({1'b0, xl});
		p_s1[5] <= coef[7] * $signed({1'b0, yl});
		xr_s1 <= xr;
		yr_s1 <= yr;
	end

	// stage 2: line terms
	logic signed [AW-1:0] a_s2, b_s2, c_s2;
	logic [CB-1:0] xr_s2, yr_s2;
	always_ff @(posedge clk) begin
		a_s2 <= AW'(p_s1[0]) + AW'(p_s1[1]) + (AW'(coef[2]) <<< 4);
		b_s2 <= AW'(p_s1[2]) + AW'(p_s1[3]) + (AW'(coef[5]) <<< 4);
		c_s2 <= AW'(p_s1[4]) + AW'(p_s1[5]) + (AW'(coef[8]) <<< 4);
		xr_s2 <= xr_s1;
		yr_s2 <= yr_s1;
	end

	// stage 3: normalizing shift from the larger normal magnitude
	logic [AW-1:0] ma, mb, mm;
	logic [eld_pkg::SH_W-1:0] len_a, k_d;
	always_comb begin
		ma = a_s2[AW-1] ? AW'(-a_s2) : AW'(a_s2);
		mb = b_s2[AW-1] ? AW'(-b_s2) : AW'(b_s2);
		mm = (mb > ma) ? mb : ma;
		len_a = '0;
		for (int i = 0; i < AW; i++) begin
			if (mm[i]) len_a = eld_pkg::SH_W'(i + 1);
		end
		k_d = (len_a > eld_pkg::SH_W'(30)) ? len_a - eld_pkg::SH_W'(30) : '0;
	end

	logic signed [AW-1:0] a_s3, b_s3, c_s3;
	logic [eld_pkg::SH_W-1:0] k_s3;
	logic deg_s3;
	logic [CB-1:0] xr_s3, yr_s3;
	always_ff @(posedge clk) begin
		a_s3 <= a_s2;
		b_s3 <= b_s2;
		c_s3 <= c_s2;
		k_s3 <= k_d;
		deg_s3 <= (a_s2 == '0) && (b_s2 == '0);
		xr_s3 <= xr_s2;
		yr_s3 <= yr_s2;
	end

	// stage 4: floor shift of all three terms
	logic signed [eld_pkg::NORM_W-1:0] as_s4, bs_s4;
	logic signed [AW-1:0] cs_s4;
	logic deg_s4;
	logic [CB-1:0] xr_s4, yr_s4;
	always_ff @(posedge clk) begin
		as_s4 <= eld_pkg::NORM_W'(a_s3 >>> k_s3);
		bs_s4 <= eld_pkg::NORM_W'(b_s3 >>> k_s3);
		cs_s4 <= c_s3 >>> k_s3;
		deg_s4 <= deg_s3;
		xr_s4 <= xr_s3;
		yr_s4 <= yr_s3;
	end

	// stage 5: products for numerator and squares
	logic signed [MW-1:0] mx_s5, my_s5;
	logic signed [eld_pkg::SQ_W-1:0] sa_s5, sb_s5;
	logic signed [AW-1:0] cs_s5;
	logic deg_s5;
	always_ff @(posedge clk) begin
		mx_s5 <= as_s4 * $signed({1'b0, xr_s4});
		my_s5 <= bs_s4 * $signed({1'b0, yr_s4});
		sa_s5 <= as_s4 * as_s4;
		sb_s5 <= bs_s4 * bs_s4;
		cs_s5 <= cs_s4;
		deg_s5 <= deg_s4;
	end

	// stage 6: numerator and sum of squares
	logic signed [NW-1:0] num_s6;
	logic [eld_pkg::SQ_W-1:0] s_s6;
	logic deg_s6;
	always_ff @(posedge clk) begin
		num_s6 <= NW'(mx_s5) + NW'(my_s5) + (NW'(cs_s5) <<< 4);
		s_s6 <= eld_pkg::SQ_W'($unsigned(sa_s5)) + eld_pkg::SQ_W'($unsigned(sb_s5));
		deg_s6 <= deg_s5;
	end

	// stage 7: even normalization of the sum of squares to at least 2^60
	logic [eld_pkg::SH_W-1:0] len_s, gap, sh_d;
	always_comb begin
		len_s = '0;
		for (int i = 0; i < eld_pkg::SQ_W; i++) begin
			if (s_s6[i]) len_s = eld_pkg::SH_W'(i + 1);
		end
		gap = (len_s >= eld_pkg::SH_W'(61)) ? '0 : eld_pkg::SH_W'(61) - len_s;
		sh_d = gap + eld_pkg::SH_W'(gap[0]);
	end

	always_ff @(posedge clk) begin
		sq <= s_s6 << sh_d;
		anum <= num_s6[NW-1] ? NW'(-num_s6) : NW'(num_s6);
		side.neg <= num_s6[NW-1];
		side.deg <= deg_s6;
		side.h <= (sh_d >> 1) + eld_pkg::SH_W'(4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	assign out_valid = v_s7;

endmodule

>>> rtl/eld_sqrt.sv
// ----------------------------------------------------------------------------
// eld_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module eld_sqrt #(
	parameter int AN = 56
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [eld_pkg::SQ_W-1:0]      sq,
	input  logic [AN-1:0]                 anum_in,
	input  eld_pkg::side_t                side_in,
	output logic                          out_valid,
	output logic [eld_pkg::ROOT_W-1:0]    root,
	output logic [AN-1:0]                 anum_out,
	output eld_pkg::side_t                side_out
);

	localparam int N = eld_pkg::SQRT_STEPS;
	localparam int W = eld_pkg::SQ_W;

	logic [W-1:0]          n_s [1:N];
	logic [W-1:0]          r_s [1:N];
	logic [AN-1:0]         an_s [1:N];
	eld_pkg::side_t        sd_s [1:N];
	logic                  v_s [1:N];

	for (genvar j = 0; j < N; j++) begin : g_step
		localparam logic [W-1:0] BIT = W'(1) << (60 - 2 * j);
		logic [W-1:0] n_in, r_in;
		logic [AN-1:0] an_in;
		eld_pkg::side_t sd_in;
		logic v_in;
		logic [W:0] trial;

		if (j == 0) begin : g_first
			assign n_in = sq;
			assign r_in = '0;
			assign an_in = anum_in;
			assign sd_in = side_in;
			assign v_in = in_valid;
		end else begin : g_next
			assign n_in = n_s[j];
			assign r_in = r_s[j];
			assign an_in = an_s[j];
			assign sd_in = sd_s[j];
			assign v_in = v_s[j];
		end

		assign trial = {1'b0, r_in} + {1'b0, BIT};

		always_ff @(posedge clk) begin
			if ({1'b0, n_in} >= trial) begin
				n_s[j+1] <= n_in - W'(trial);
				r_s[j+1] <= (r_in >> 1) + BIT;
			end else begin
				n_s[j+1] <= n_in;
				r_s[j+1] <= r_in >> 1;
			end
			an_s[j+1] <= an_in;
			sd_s[j+1] <= sd_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_in;
			end
		end
	end

	assign out_valid = v_s[N];
	assign root = r_s[N][eld_pkg::ROOT_W-1:0];
	assign anum_out = an_s[N];
	assign side_out = sd_s[N];

endmodule

>>> rtl/eld_div.sv
// ----------------------------------------------------------------------------
// eld_div
// Saturation check, pipelined rounding divide and result formatting.
// ----------------------------------------------------------------------------
module eld_div #(
	parameter int AN = 56
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic [eld_pkg::ROOT_W-1:0]           root,
	input  logic [AN-1:0]                        anum,
	input  eld_pkg::side_t                       side_in,
	output logic                                 done,
	output logic signed [eld_pkg::QUO_W-1:0]     distance,
	output logic                                 degenerate,
	output logic                                 saturated
);

	localparam int N = eld_pkg::DIV_STEPS;
	localparam int DW = eld_pkg::DVD_W;
	localparam int LW = eld_pkg::LIM_W;
	localparam int QW = eld_pkg::QUO_W;

	// limit stage: (2^23+1)*root >> h, and the rounded dividend
	logic [LW-1:0] lim, limh;
	logic sat_d;
	always_comb begin
		lim = (LW'(root) << 23) + LW'(root);
		limh = lim >> side_in.h;
		sat_d = 64'(anum) > 64'(limh);
	end

	logic [DW-1:0]             rem_s [0:N];
	logic [QW-1:0]             q_s [0:N];
	logic [eld_pkg::ROOT_W-1:0] d_s [0:N];
	eld_pkg::side_t            sd_s [0:N];
	logic                      sat_s [0:N];
	logic                      v_s [0:N];

	always_ff @(posedge clk) begin
		rem_s[0] <= (DW'(anum) << side_in.h) + DW'(root >> 1);
		q_s[0] <= '0;
		d_s[0] <= root;
		sd_s[0] <= side_in;
		sat_s[0] <= sat_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	// restoring divide, quotient MSB first
	for (genvar j = 0; j < N; j++) begin : g_step
		logic [DW-1:0] dsh;
		assign dsh = DW'(d_s[j]) << (N - 1 - j);

		always_ff @(posedge clk) begin
			if (rem_s[j] >= dsh) begin
				rem_s[j+1] <= rem_s[j] - dsh;
				q_s[j+1] <= q_s[j] | (QW'(1) << (N - 1 - j));
			end else begin
				rem_s[j+1] <= rem_s[j];
				q_s[j+1] <= q_s[j];
			end
			d_s[j+1] <= d_s[j];
			sd_s[j+1] <= sd_s[j];
			sat_s[j+1] <= sat_s[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end
	end

	// clamp and sign
	logic [QW-1:0] cap, mag;
	logic sat_f;
	always_comb begin
		cap = sd_s[N].neg ? eld_pkg::NEG_CAP : eld_pkg::POS_CAP;
		if (sat_s[N] || (q_s[N] > cap)) begin
			mag = cap;
			sat_f = 1'b1;
		end else begin
			mag = q_s[N];
			sat_f = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sd_s[N].deg) begin
			distance <= '0;
			degenerate <= 1'b1;
			saturated <= 1'b0;
		end else begin
			distance <= sd_s[N].neg ? $signed(-mag) : $signed(mag);
			degenerate <= 1'b0;
			saturated <= sat_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s[N];
		end
	end

endmodule
